// ----- rtl/core/mme_pkg.sv -----
// Shared types and constants for the matrix multiply engine.
// No dependencies.
package mme_pkg;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned SUM_W  = 38;
  localparam int unsigned ROW_W  = 16;
  localparam int unsigned OCOL_W = 6;
  localparam int unsigned REG_W  = 16;
  localparam int unsigned RIDX_W = 2;

  // register indexes on the configuration port
  localparam logic [RIDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [RIDX_W-1:0] REG_INNER_SIZE   = 2'd1;
  localparam logic [RIDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

  // input word kinds
  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_LHS    = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [ELEM_W-1:0] element;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] product_sum;
    logic [ROW_W-1:0]        out_row;
    logic [OCOL_W-1:0]       out_column;
    logic                    row_last;
    logic                    matrix_last;
  } out_word_t;

  // broadcast control from the sequencer to every column cell
  typedef struct packed {
    logic                     clear;
    logic                     mac;
    logic                     row_end;
    logic                     shift;
    logic signed [ELEM_W-1:0] mac_elem;
    logic signed [ELEM_W-1:0] wr_data;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/mme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mme_cell.sv -----
// One column cell: weight column RAM, MAC accumulator and a drain stage
// that hands its result to the neighbor toward the output.
// Depends on mme_pkg and mme_ram.
module mme_cell #(
  parameter int unsigned MAX_INNER = 64,
  localparam int unsigned IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mme_pkg::cell_ctrl_t              ctrl_i,
  input  logic                             we_i,
  input  logic [IW-1:0]                    waddr_i,
  input  logic [IW-1:0]                    raddr_i,
  input  logic signed [mme_pkg::SUM_W-1:0] drain_i,
  output logic signed [mme_pkg::SUM_W-1:0] drain_o
);

  logic [mme_pkg::ELEM_W-1:0]       w_rd;
  logic signed [2*mme_pkg::ELEM_W-1:0] prod;
  logic signed [mme_pkg::SUM_W-1:0] sum_d, sum_q;
  logic signed [mme_pkg::SUM_W-1:0] acc;
  logic signed [mme_pkg::SUM_W-1:0] drain_d, drain_q;

  mme_ram #(
    .WIDTH(mme_pkg::ELEM_W),
    .DEPTH(MAX_INNER)
  ) u_wram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(ctrl_i.wr_data),
    .raddr_i(raddr_i),
    .rdata_o(w_rd)
  );

  assign prod = ctrl_i.mac_elem * $signed(w_rd);
  assign acc  = sum_q + mme_pkg::SUM_W'(prod);

  always_comb begin
    sum_d   = sum_q;
    drain_d = drain_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.mac) begin
      if (ctrl_i.row_end) begin
        drain_d = acc;
        sum_d   = '0;
      end else begin
        sum_d = acc;
      end
    end
    if (ctrl_i.shift) begin
      drain_d = drain_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drain_q <= drain_d;
  end

  assign drain_o = drain_q;

endmodule

// ----- rtl/core/matrix_multiply_engine.sv -----
// Top level of the matrix multiply engine: sequencer, size registers and
// the chain of column cells. Depends on mme_pkg and mme_cell.
//
// Usage:
//  - cfg channel (valid/ready, always ready): index 0 row_count, 1 inner_size,
//    2 column_count. A write to one of these restarts the block (reload weights).
//  - in channel (valid/stall): kind 0 words load rhs weights row-major,
//    kind 1 words stream lhs elements row-major. Lhs words before a full
//    weight load are dropped. A weight word after a full load starts a new
//    load and discards the partial row.
//  - out channel (valid/stall): column_count words per finished lhs row,
//    column order, with row_last / matrix_last flags.
// Timing: the input stalls during the multiply-add of an accepted lhs word, not after a
//  weight word. The column RAMs are read at the accepting edge; the next cycle does the
//  multiply-add in every cell. The row-ending multiply-add loads the drain stages, and
//  results then leave one per cycle while the output is not stalled, as the drain chain
//  shifts toward cell 0. A word that would end a row waits while the previous row
//  still drains. Other words are taken during the drain.
// Reset: sizes go to 1, counters and accumulators clear, no weights loaded.
// A stalled output holds its word; the drain chain moves only on accept.
module matrix_multiply_engine #(
  parameter int unsigned MAX_INNER   = 64,
  parameter int unsigned MAX_COLUMNS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mme_pkg::RIDX_W-1:0]    cfg_index_i,
  input  logic [mme_pkg::REG_W-1:0]     cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mme_pkg::in_word_t             in_word_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mme_pkg::out_word_t            out_word_o
);

  localparam int unsigned IW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned EIW = $clog2(MAX_INNER + 1);
  localparam int unsigned ECW = $clog2(MAX_COLUMNS + 1);

  // size registers
  logic [15:0] row_count_q;
  logic [6:0]  inner_size_q, column_count_q;

  // effective sizes
  logic [15:0]    eff_rows;
  logic [EIW-1:0] eff_inner;
  logic [ECW-1:0] eff_cols;

  // sequencer state
  logic          ready_q, ready_d;
  logic [IW-1:0] wk_q, wk_d;       // weight load: inner row
  logic [CW-1:0] wc_q, wc_d;       // weight load: column
  logic [IW-1:0] ip_q, ip_d;       // lhs inner position
  logic [15:0]   rp_q, rp_d;       // lhs row position
  logic          mac_v_q, mac_v_d;
  logic          mac_end_q, mac_end_d;
  logic signed [mme_pkg::ELEM_W-1:0] elem_q;
  logic          drain_q, drain_d;
  logic [CW-1:0] oc_q, oc_d;       // output column
  logic [15:0]   orow_q;
  logic          olast_q;

  logic cfg_wr, cfg_hit, in_acc, out_acc, w_acc, l_acc, restart;
  logic [IW-1:0] wk_sel;
  logic [CW-1:0] wc_sel;
  logic row_end_next, wc_end, wk_end, last_row, oc_end;
  logic [MAX_COLUMNS-1:0] cell_we;

  mme_pkg::cell_ctrl_t ctrl;
  logic signed [mme_pkg::SUM_W-1:0] chain [MAX_COLUMNS+1];

  // ---------------------------------------------------------------------
  // effective sizes: zero acts as one, clamp to the build limits
  always_comb begin
    eff_rows = (row_count_q == '0) ? 16'd1 : row_count_q;
    if (inner_size_q == '0) begin
      eff_inner = EIW'(1);
    end else if (32'(inner_size_q) > 32'(MAX_INNER)) begin
      eff_inner = EIW'(MAX_INNER);
    end else begin
      eff_inner = EIW'(inner_size_q);
    end
    if (column_count_q == '0) begin
      eff_cols = ECW'(1);
    end else if (32'(column_count_q) > 32'(MAX_COLUMNS)) begin
      eff_cols = ECW'(MAX_COLUMNS);
    end else begin
      eff_cols = ECW'(column_count_q);
    end
  end

  // ---------------------------------------------------------------------
  // handshakes
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr       = cfg_valid_i && cfg_ready_o;
  // writes to an index with no register leave the block untouched
  assign cfg_hit      = cfg_wr && (cfg_index_i == mme_pkg::REG_ROW_COUNT ||
                                   cfg_index_i == mme_pkg::REG_INNER_SIZE ||
                                   cfg_index_i == mme_pkg::REG_COLUMN_COUNT);
  assign row_end_next = ready_q && (EIW'(ip_q) + EIW'(1) == eff_inner);
  assign in_stall_o   = mac_v_q || (drain_q && row_end_next);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign w_acc        = in_acc && (in_word_i.kind == mme_pkg::KIND_WEIGHT);
  assign l_acc        = in_acc && (in_word_i.kind == mme_pkg::KIND_LHS) && ready_q;
  assign out_valid_o  = drain_q;
  assign out_acc      = out_valid_o && !out_stall_i;

  // a weight word after a full load begins a fresh load at position 0
  assign restart = cfg_hit || (w_acc && ready_q);
  assign wk_sel  = ready_q ? '0 : wk_q;
  assign wc_sel  = ready_q ? '0 : wc_q;
  assign wc_end  = (ECW'(wc_sel) + ECW'(1) == eff_cols);
  assign wk_end  = (EIW'(wk_sel) + EIW'(1) == eff_inner);
  assign last_row = ({1'b0, rp_q} + 17'd1 >= {1'b0, eff_rows});
  assign oc_end  = (ECW'(oc_q) + ECW'(1) == eff_cols);

  // ---------------------------------------------------------------------
  // sequencer next state
  always_comb begin
    ready_d   = ready_q;
    wk_d      = wk_q;
    wc_d      = wc_q;
    ip_d      = ip_q;
    rp_d      = rp_q;
    mac_v_d   = l_acc;
    mac_end_d = l_acc && row_end_next;
    drain_d   = drain_q;
    oc_d      = oc_q;

    if (cfg_hit) begin
      ready_d = 1'b0;
      wk_d    = '0;
      wc_d    = '0;
      ip_d    = '0;
      rp_d    = '0;
    end else if (w_acc) begin
      ip_d = '0;
      rp_d = '0;
      if (wc_end) begin
        wc_d = '0;
        if (wk_end) begin
          wk_d    = '0;
          ready_d = 1'b1;
        end else begin
          wk_d    = wk_sel + IW'(1);
          ready_d = 1'b0;
        end
      end else begin
        wc_d    = wc_sel + CW'(1);
        wk_d    = wk_sel;
        ready_d = 1'b0;
      end
    end else if (l_acc) begin
      if (row_end_next) begin
        ip_d = '0;
        rp_d = last_row ? '0 : rp_q + 16'd1;
      end else begin
        ip_d = ip_q + IW'(1);
      end
    end

    // drain: start when the row-ending MAC lands, stop after last column
    if (mac_v_q && mac_end_q) begin
      drain_d = 1'b1;
      oc_d    = '0;
    end else if (out_acc) begin
      if (oc_end) begin
        drain_d = 1'b0;
      end else begin
        oc_d = oc_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 16'd1;
      inner_size_q   <= 7'd1;
      column_count_q <= 7'd1;
      ready_q        <= 1'b0;
      wk_q           <= '0;
      wc_q           <= '0;
      ip_q           <= '0;
      rp_q           <= '0;
      mac_v_q        <= 1'b0;
      mac_end_q      <= 1'b0;
      drain_q        <= 1'b0;
      oc_q           <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index_i)
          mme_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
          mme_pkg::REG_INNER_SIZE:   inner_size_q   <= cfg_data_i[6:0];
          mme_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      ready_q   <= ready_d;
      wk_q      <= wk_d;
      wc_q      <= wc_d;
      ip_q      <= ip_d;
      rp_q      <= rp_d;
      mac_v_q   <= mac_v_d;
      mac_end_q <= mac_end_d;
      drain_q   <= drain_d;
      oc_q      <= oc_d;
    end
  end

  // payload registers: element for the MAC stage, row tag for the drain
  always_ff @(posedge clk_i) begin
    if (l_acc) begin
      elem_q <= in_word_i.element;
      if (row_end_next) begin
        orow_q  <= rp_q;
        olast_q <= last_row;
      end
    end
  end

  // ---------------------------------------------------------------------
  // column cells; drain values shift toward cell 0
  always_comb begin
    ctrl.clear    = restart;
    ctrl.mac      = mac_v_q;
    ctrl.row_end  = mac_end_q;
    ctrl.shift    = out_acc;
    ctrl.mac_elem = elem_q;
    ctrl.wr_data  = in_word_i.element;
  end

  assign chain[MAX_COLUMNS] = '0;

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_cell
    assign cell_we[c] = w_acc && (wc_sel == CW'(c));

    mme_cell #(
      .MAX_INNER(MAX_INNER)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .we_i   (cell_we[c]),
      .waddr_i(wk_sel),
      .raddr_i(ip_q),
      .drain_i(chain[c+1]),
      .drain_o(chain[c])
    );
  end

  // ---------------------------------------------------------------------
  // result word
  always_comb begin
    out_word_o.product_sum = chain[0];
    out_word_o.out_row     = orow_q;
    out_word_o.out_column  = mme_pkg::OCOL_W'(oc_q);
    out_word_o.row_last    = oc_end;
    out_word_o.matrix_last = oc_end && olast_q;
  end

endmodule
